FILE: design/mh64_pkg.sv
`default_nettype none

package mh64_pkg;

  // Mixing multiplier, shift distance and the reset value of the seed register.
  localparam logic [63:0] MUR_M      = 64'hc6a4a7935bd1e995;
  localparam logic [5:0]  MUR_R      = 6'd47;
  localparam logic [63:0] SEED_RESET = 64'hdeadbeefdeadbeef;

  // Key byte count of a full word.
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_DISP,
    ST_K1,
    ST_K2,
    ST_HM,
    ST_FMUL,
    ST_OUT
  } mh64_state_e;

  // Start request to the shared multiply unit.
  typedef struct packed {
    logic        start;
    logic [63:0] opnd;
  } mh64_mul_req_t;

  // Steps of one 64-bit multiply on the 32x32 multiplier.
  typedef enum logic [1:0] {
    MS_LOLO,
    MS_HILO,
    MS_LOHI,
    MS_SUM
  } mh64_mstep_e;

endpackage : mh64_pkg

`default_nettype wire

FILE: design/mh64_mul.sv
`default_nettype none

// Shared multiply unit: computes opnd * MUR_M modulo 2^64 with one 32x32 multiplier.
// The operand is captured at start; the product is valid while done_o is high
// and holds until the next start.
module mh64_mul import mh64_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mh64_mul_req_t req_i,
  output logic               done_o,
  output logic [63:0]        prod_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  mh64_mstep_e step_q, step_d;
  logic [63:0] a_q, a_d;
  logic [63:0] pp_q, pp_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] op_a, op_b;
  logic [63:0] prod_c;

  // Operand halves for the current partial product.
  always_comb begin
    op_a = a_q[31:0];
    op_b = MUR_M[31:0];
    case (step_q)
      MS_HILO: begin
        op_a = a_q[63:32];
        op_b = MUR_M[31:0];
      end
      MS_LOHI: begin
        op_a = a_q[31:0];
        op_b = MUR_M[63:32];
      end
      default: begin
        op_a = a_q[31:0];
        op_b = MUR_M[31:0];
      end
    endcase
  end

  assign prod_c = {32'h0, op_a} * {32'h0, op_b};

  // Step sequence: low product, then the two cross products shifted up by 32 bits.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    pp_d   = pp_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = MS_LOLO;
      a_d    = req_i.opnd;
    end else if (busy_q) begin
      unique case (step_q)
        MS_LOLO: begin
          pp_d   = prod_c;
          step_d = MS_HILO;
        end
        MS_HILO: begin
          acc_d  = pp_q;
          pp_d   = prod_c;
          step_d = MS_LOHI;
        end
        MS_LOHI: begin
          acc_d  = acc_q + {pp_q[31:0], 32'h0};
          pp_d   = prod_c;
          step_d = MS_SUM;
        end
        MS_SUM: begin
          acc_d  = acc_q + {pp_q[31:0], 32'h0};
          busy_d = 1'b0;
          done_d = 1'b1;
          step_d = MS_LOLO;
        end
        default: begin
          step_d = MS_LOLO;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= MS_LOLO;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule : mh64_mul

`default_nettype wire

FILE: design/murmur_hash_64a.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    word_i, valid_bytes_i, last_i,
//                                                 message_length_i
// output    out        out_valid_o / out_stall_i  hash_o
// config    in         cfg_we_i                   cfg_wdata_i (seed)
//
// Every 64-bit multiply runs on one shared 32x32 multiplier.
// A full word takes three multiplies, the first word of a key adds one more for seeding,
// a tail adds one, and the last word adds one for the avalanche before the hash is
// loaded into the output register.
// in_stall_o is high from acceptance of a request until its work is done.
// A finished hash waits in the sequencer while the output register is still stalled.
// Reset sets the seed to its default and clears all control state.
module murmur_hash_64a import mh64_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic        last_i,
  input  wire logic [30:0] message_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_o
);

  mh64_state_e   state_q, state_d;
  logic          mid_q, mid_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   seed_q;
  logic [63:0]   h_q, h_d;
  logic [63:0]   word_q, word_d;
  logic [3:0]    nb_q, nb_d;
  logic          last_q, last_d;
  logic [63:0]   hash_q, hash_d;
  mh64_mul_req_t mul_req;
  logic          mul_done;
  logic [63:0]   mul_p;
  logic          in_acc;
  logic [63:0]   tail_mask;
  logic [63:0]   p_fold;
  logic [63:0]   h_fold;

  // Shared multiply unit.
  mh64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Byte mask for a tail of one to seven bytes.
  assign tail_mask = (64'h1 << {nb_q[2:0], 3'b000}) - 64'h1;
  assign p_fold    = mul_p ^ (mul_p >> MUR_R);
  assign h_fold    = h_q ^ (h_q >> MUR_R);

  // Sequencer: next state, multiply requests and register updates.
  always_comb begin
    state_d      = state_q;
    mid_d        = mid_q;
    h_d          = h_q;
    word_d       = word_q;
    nb_d         = nb_q;
    last_d       = last_q;
    hash_d       = hash_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mul_req      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          word_d = word_i;
          nb_d   = valid_bytes_i[3] ? FULL_BYTES : valid_bytes_i;
          last_d = last_i;
          if (mid_q) begin
            state_d = ST_DISP;
          end else begin
            mul_req.start = 1'b1;
            mul_req.opnd  = {33'h0, message_length_i};
            state_d       = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          h_d     = seed_q ^ mul_p;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        if (nb_q[3]) begin
          mul_req.start = 1'b1;
          mul_req.opnd  = word_q;
          state_d       = ST_K1;
        end else if (last_q && (nb_q != 4'd0)) begin
          mul_req.start = 1'b1;
          mul_req.opnd  = h_q ^ (word_q & tail_mask);
          state_d       = ST_HM;
        end else if (last_q) begin
          mul_req.start = 1'b1;
          mul_req.opnd  = h_fold;
          state_d       = ST_FMUL;
        end else begin
          // A short word that is not last adds no bytes.
          mid_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_K1: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.opnd  = p_fold;
          state_d       = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.opnd  = h_q ^ mul_p;
          state_d       = ST_HM;
        end
      end
      ST_HM: begin
        if (mul_done) begin
          h_d = mul_p;
          if (last_q) begin
            mul_req.start = 1'b1;
            mul_req.opnd  = p_fold;
            state_d       = ST_FMUL;
          end else begin
            mid_d   = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_FMUL: begin
        if (mul_done) begin
          h_d     = p_fold;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          hash_d      = h_q;
          out_valid_d = 1'b1;
          h_d         = '0;
          mid_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= SEED_RESET;
    end else begin
      state_q     <= state_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    word_q <= word_d;
    nb_q   <= nb_d;
    last_q <= last_d;
    hash_q <= hash_d;
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  // A multiply result never arrives while the sequencer waits for a request.
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q != ST_IDLE))
    else $error("multiply finished while idle");

  // A new result appears only from the output state.
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output state");

  // The first word of a key always starts with the seeding multiply.
  a_seed_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !mid_q) |=> (state_q == ST_SEED))
    else $error("first word did not seed the hash");

  // A multiply is never restarted while the sequencer still waits for its result in ST_K1 or ST_K2.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_req.start && (state_q == ST_K1 || state_q == ST_K2)) |-> mul_done)
    else $error("multiply restarted before completion");

endmodule : murmur_hash_64a

`default_nettype wire

FILE: tb/tb_murmur_hash_64a.sv
`default_nettype none

module tb_murmur_hash_64a import mh64_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the block settle after its last result, and the quiet-cycle limit.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned TARGET_WORDS  = 1600;

  // Receiver stall behavior, changed now and then.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_LONG
  } rx_mode_e;

  // Key shapes for the random part.
  typedef enum logic [1:0] {
    KEY_WELL_FORMED,
    KEY_LENGTH_LIE,
    KEY_NOISE
  } key_kind_e;

  // Tracks the seed and the running hash, and holds the hashes still owed by the block.
  class murmur_scoreboard;
    logic [63:0] seed;
    logic [63:0] partial_hash;
    bit          in_key;
    logic [63:0] pending_hashes[$];
    int unsigned mismatches;

    function new();
      seed         = SEED_RESET;
      partial_hash = '0;
      in_key       = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_seed(logic [63:0] value);
      seed = value;
    endfunction

    // Advances the hash state by one accepted request and queues a finished hash if any.
    function void note_request(logic [63:0] word, logic [3:0] nbytes, logic last,
                               logic [30:0] msg_len);
      logic [63:0] acc;
      logic [63:0] k;
      logic [63:0] mask;
      int unsigned n;
      n   = (nbytes > 4'd8) ? 8 : int'(nbytes);
      acc = in_key ? partial_hash : (seed ^ ({33'd0, msg_len} * MUR_M));
      if (n == 8) begin
        k   = word * MUR_M;
        k   = k ^ (k >> 47);
        k   = k * MUR_M;
        acc = (acc ^ k) * MUR_M;
      end else if (last && n > 0) begin
        mask = (64'd1 << (8 * n)) - 64'd1;
        acc  = (acc ^ (word & mask)) * MUR_M;
      end
      if (last) begin
        acc = acc ^ (acc >> 47);
        acc = acc * MUR_M;
        acc = acc ^ (acc >> 47);
        pending_hashes = {pending_hashes, acc};
        partial_hash = '0;
        in_key       = 1'b0;
      end else begin
        partial_hash = acc;
        in_key       = 1'b1;
      end
    endfunction

    // Compares a hash leaving the block with the oldest one owed.
    function void check_hash(logic [63:0] actual);
      logic [63:0] owed;
      if (pending_hashes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected hash %h, none owed", $time, actual);
      end else begin
        owed = pending_hashes.pop_front();
        if (actual !== owed) begin
          mismatches++;
          $display("%0t: hash expected %h actual %h", $time, owed, actual);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] word = '0;
  logic [3:0]  valid_bytes = '0;
  logic        last = 1'b0;
  logic [30:0] message_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] hash;

  murmur_scoreboard sb = new();

  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_e    stall_mode = RX_FREE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  murmur_hash_64a DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .word_i           (word),
    .valid_bytes_i    (valid_bytes),
    .last_i           (last),
    .message_length_i (message_length),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .hash_o           (hash)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver switches between free running, random stalls and long stall runs.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= rx_mode_e'($urandom_range(0, 2));
      mode_left  <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_RANDOM: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(1, 25);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // Every hash that leaves the block is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_hash(hash);
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Lowers valid for a number of cycles.
  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // Offers one request and waits until the block takes it. Bursts end in random gaps.
  task automatic send_word(logic [63:0] w, logic [3:0] nbytes, logic lst, logic [30:0] len);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 12));
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid       <= 1'b1;
    word           <= w;
    valid_bytes    <= nbytes;
    last           <= lst;
    message_length <= len;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    sb.note_request(w, nbytes, lst, len);
    words_sent++;
  endtask

  // Stops offering requests and waits until the block has nothing left to do.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_hashes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [63:0] value);
    settle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.set_seed(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Sends a key of len bytes as full words and a tail, with the given length field.
  task automatic send_key_bytes(int unsigned len, logic [30:0] len_field);
    int unsigned n_full;
    int unsigned tail;
    int unsigned n_words;
    logic [3:0]  nbytes;
    n_full  = len / 8;
    tail    = len % 8;
    n_words = (tail != 0 || len == 0) ? n_full + 1 : n_full;
    for (int unsigned i = 0; i < n_words; i++) begin
      nbytes = (i < n_full) ? FULL_BYTES : 4'(tail);
      // Only the first word's length counts; later ones carry junk.
      send_word(rand64(), nbytes, i == n_words - 1,
                (i == 0) ? len_field : 31'($urandom));
    end
  endtask

  task automatic send_random_key();
    key_kind_e   kind;
    int unsigned len;
    int unsigned n_noise;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    kind = (pick < 7) ? KEY_WELL_FORMED : (pick < 8) ? KEY_LENGTH_LIE : KEY_NOISE;
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 24);
    case (kind)
      KEY_WELL_FORMED: begin
        send_key_bytes(len, 31'(len));
      end
      KEY_LENGTH_LIE: begin
        send_key_bytes(len, ($urandom_range(0, 1) == 1) ? 31'($urandom) : 31'h7fffffff);
      end
      default: begin
        // Arbitrary byte counts, oversized ones too, and a random end of key.
        n_noise = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n_noise; i++) begin
          send_word(rand64(), 4'($urandom_range(0, 15)),
                    (i == n_noise - 1) || ($urandom_range(0, 3) == 0), 31'($urandom));
        end
      end
    endcase
  endtask

  initial begin
    logic [63:0] phase_seed;
    int unsigned phase;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys under the reset seed: empty key, full last word, short tails.
    send_word(rand64(), 4'd0, 1'b1, 31'd0);
    send_word(64'hffffffffffffffff, FULL_BYTES, 1'b1, 31'd8);
    send_word(rand64(), 4'd3, 1'b1, 31'd3);
    send_word(64'hffffffffffffffff, 4'd7, 1'b1, 31'd7);
    send_word(64'd0, FULL_BYTES, 1'b0, 31'd15);
    send_word(64'hffffffffffffffff, 4'd7, 1'b1, 31'd0);

    // Oversized byte counts count as a full word.
    send_word(rand64(), 4'd15, 1'b0, 31'd16);
    send_word(rand64(), 4'd9, 1'b1, 31'd0);

    // A short first word that is not last still seeds, here with the largest length.
    send_word(rand64(), 4'd3, 1'b0, 31'h7fffffff);
    send_word(rand64(), FULL_BYTES, 1'b1, 31'd0);

    // A seed change in the middle of a key leaves that key alone.
    send_word(rand64(), FULL_BYTES, 1'b0, 31'd12);
    write_seed(64'd0);
    send_word(rand64(), 4'd4, 1'b1, 31'd5);

    // Empty keys under a zero seed with extreme lengths, then an all-ones seed.
    send_word(64'd0, 4'd0, 1'b1, 31'd0);
    send_word(rand64(), 4'd0, 1'b1, 31'h7fffffff);
    write_seed(64'hffffffffffffffff);
    send_word(64'h00000000000000ff, 4'd1, 1'b1, 31'd1);
    send_word(64'd0, 4'd0, 1'b1, 31'd0);

    // Random keys in phases, each with a new seed.
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      case (phase % 6)
        0: phase_seed = SEED_RESET;
        1: phase_seed = 64'd0;
        2: phase_seed = 64'hffffffffffffffff;
        default: phase_seed = rand64();
      endcase
      write_seed(phase_seed);
      repeat ($urandom_range(20, 40)) send_random_key();
      phase++;
    end

    settle();
    while (sb.pending_hashes.size() != 0) begin
      $display("%0t: hash expected %h actual none", $time, sb.pending_hashes.pop_front());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
